@@ src/bw_pkg.sv @@
// ----------------------------------------------------------------------------
// Barycentric weights package
// Shared constants and the classification flags that travel with a request.
// ----------------------------------------------------------------------------
package bw_pkg;

    // Default parameter values
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Fixed width of a result weight
    localparam int WEIGHT_BITS = 20;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Per-request classification decided in the front part
    typedef struct packed {
        logic neg0;        // weight0 quotient is negative
        logic neg1;        // weight1 quotient is negative
        logic degenerate;  // determinant is zero
    } bw_flags_t;

endpackage

@@ src/barycentric_weights_core.sv @@
// ----------------------------------------------------------------------------
// Barycentric weights core
// Barycentric weights of a test point against a 2D triangle, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one request per cycle while
//   in_stall is low: a test point and three vertices. Output channel
//   (out_valid / out_stall) gives three weights with FRAC_BITS fraction
//   bits, plus degenerate and saturated flags, one result per request, in
//   order. The back part uses a pipelined restoring divider, one quotient
//   bit per stage. Throughput is one request per cycle while the output
//   is not stalled.
//   The front part (products, sums, classification) feeds a four entry
//   queue; the back part (two dividers sharing a determinant, weight
//   combine and saturation) drains it. When the receiver stalls, the back
//   part freezes, the queue fills and in_stall rises once it is full.
//   Reset clears all valid state; no clearing pass is needed, the block
//   takes requests from the first cycle after reset.
// ----------------------------------------------------------------------------
module barycentric_weights_core
    import bw_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_BITS-1:0]  point_x,
    input  logic signed [COORD_BITS-1:0]  point_y,
    input  logic signed [COORD_BITS-1:0]  vertex0_x,
    input  logic signed [COORD_BITS-1:0]  vertex0_y,
    input  logic signed [COORD_BITS-1:0]  vertex1_x,
    input  logic signed [COORD_BITS-1:0]  vertex1_y,
    input  logic signed [COORD_BITS-1:0]  vertex2_x,
    input  logic signed [COORD_BITS-1:0]  vertex2_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [WEIGHT_BITS-1:0] weight0,
    output logic signed [WEIGHT_BITS-1:0] weight1,
    output logic signed [WEIGHT_BITS-1:0] weight2,
    output logic                          degenerate,
    output logic                          saturated
);

    localparam int MW = 2 * COORD_BITS + 3;
    localparam int FW = $bits(bw_flags_t);
    localparam int QDW = 3 * MW + FW;

    logic            push, pop, q_full, q_not_empty;
    logic [MW-1:0]   f_mag0, f_mag1, f_magd;
    bw_flags_t       f_flags;
    logic [QDW-1:0]  q_wdata, q_rdata;

    bw_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .point_x   (point_x),
        .point_y   (point_y),
        .vertex0_x (vertex0_x),
        .vertex0_y (vertex0_y),
        .vertex1_x (vertex1_x),
        .vertex1_y (vertex1_y),
        .vertex2_x (vertex2_x),
        .vertex2_y (vertex2_y),
        .q_full    (q_full),
        .push      (push),
        .mag0      (f_mag0),
        .mag1      (f_mag1),
        .magd      (f_magd),
        .flags     (f_flags)
    );

    // Pack a classified request for the queue
    assign q_wdata = {f_mag0, f_mag1, f_magd, f_flags};

    bw_fifo #(.WIDTH(QDW), .DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (q_wdata),
        .pop       (pop),
        .rdata     (q_rdata),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    bw_back #(.MAG_BITS(MW), .FRAC(FRAC_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_not_empty),
        .q_mag0     (q_rdata[QDW-1 -: MW]),
        .q_mag1     (q_rdata[QDW-MW-1 -: MW]),
        .q_magd     (q_rdata[FW +: MW]),
        .q_flags    (q_rdata[FW-1:0]),
        .q_pop      (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .weight0    (weight0),
        .weight1    (weight1),
        .weight2    (weight2),
        .degenerate (degenerate),
        .saturated  (saturated)
    );

endmodule

@@ src/bw_front.sv @@
// ----------------------------------------------------------------------------
// Barycentric weights front part
// Accepts requests, forms the cross products and classifies each request.
// ----------------------------------------------------------------------------
module bw_front
    import bw_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_BITS-1:0]  point_x,
    input  logic signed [COORD_BITS-1:0]  point_y,
    input  logic signed [COORD_BITS-1:0]  vertex0_x,
    input  logic signed [COORD_BITS-1:0]  vertex0_y,
    input  logic signed [COORD_BITS-1:0]  vertex1_x,
    input  logic signed [COORD_BITS-1:0]  vertex1_y,
    input  logic signed [COORD_BITS-1:0]  vertex2_x,
    input  logic signed [COORD_BITS-1:0]  vertex2_y,
    input  logic                          q_full,
    output logic                          push,
    output logic [2*COORD_BITS+2:0]       mag0,
    output logic [2*COORD_BITS+2:0]       mag1,
    output logic [2*COORD_BITS+2:0]       magd,
    output bw_flags_t                     flags
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;
    localparam int NW = 2 * COORD_BITS + 3;

    logic                 adv;
    logic signed [DW-1:0] dx, dy, dy12, dx21, dy20, dx02, dy02;
    logic                 s1_valid_reg, s1_valid_next;
    logic                 s2_valid_reg, s2_valid_next;
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg;
    logic signed [NW-1:0] n0_reg, n1_reg, d_reg;
    logic signed [NW-1:0] neg_n0, neg_n1, neg_d;
    logic                 d_zero;

    // Advance whenever the last stage is empty or the queue has room
    assign adv      = !s2_valid_reg || !q_full;
    assign in_stall = !adv;

    // Edge differences
    assign dx   = $signed({point_x[COORD_BITS-1], point_x})
                - $signed({vertex2_x[COORD_BITS-1], vertex2_x});
    assign dy   = $signed({point_y[COORD_BITS-1], point_y})
                - $signed({vertex2_y[COORD_BITS-1], vertex2_y});
    assign dy12 = $signed({vertex1_y[COORD_BITS-1], vertex1_y})
                - $signed({vertex2_y[COORD_BITS-1], vertex2_y});
    assign dx21 = $signed({vertex2_x[COORD_BITS-1], vertex2_x})
                - $signed({vertex1_x[COORD_BITS-1], vertex1_x});
    assign dy20 = $signed({vertex2_y[COORD_BITS-1], vertex2_y})
                - $signed({vertex0_y[COORD_BITS-1], vertex0_y});
    assign dx02 = $signed({vertex0_x[COORD_BITS-1], vertex0_x})
                - $signed({vertex2_x[COORD_BITS-1], vertex2_x});
    assign dy02 = $signed({vertex0_y[COORD_BITS-1], vertex0_y})
                - $signed({vertex2_y[COORD_BITS-1], vertex2_y});

    assign s1_valid_next = adv ? in_valid : s1_valid_reg;
    assign s2_valid_next = adv ? s1_valid_reg : s2_valid_reg;

    // Hold stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Register products, then their sums
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg <= dy12 * dx;
            pb_reg <= dx21 * dy;
            pc_reg <= dy20 * dx;
            pd_reg <= dx02 * dy;
            pe_reg <= dy12 * dx02;
            pf_reg <= dx21 * dy02;
            n0_reg <= NW'(pa_reg) + NW'(pb_reg);
            n1_reg <= NW'(pc_reg) + NW'(pd_reg);
            d_reg  <= NW'(pe_reg) + NW'(pf_reg);
        end
    end

    // Classify and take magnitudes
    assign neg_n0 = -n0_reg;
    assign neg_n1 = -n1_reg;
    assign neg_d  = -d_reg;
    assign d_zero = (d_reg == '0);

    assign push             = s2_valid_reg && !q_full;
    assign mag0             = n0_reg[NW-1] ? neg_n0 : n0_reg;
    assign mag1             = n1_reg[NW-1] ? neg_n1 : n1_reg;
    assign magd             = d_zero ? NW'(1) : (d_reg[NW-1] ? neg_d : d_reg);
    assign flags.neg0       = n0_reg[NW-1] ^ d_reg[NW-1];
    assign flags.neg1       = n1_reg[NW-1] ^ d_reg[NW-1];
    assign flags.degenerate = d_zero;

endmodule

@@ src/bw_fifo.sv @@
// ----------------------------------------------------------------------------
// Barycentric weights request queue
// Short queue that decouples the front part from the divider back part.
// ----------------------------------------------------------------------------
module bw_fifo
    import bw_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             not_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store an incoming request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && count_reg == '0))
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && count_reg == CW'(DEPTH)))
        else $error("queue pushed while full");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue fill level out of range");

endmodule

@@ src/bw_div.sv @@
// ----------------------------------------------------------------------------
// Barycentric weights divider
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// ----------------------------------------------------------------------------
module bw_div
    import bw_pkg::*;
#(
    parameter int MAG_BITS = 2 * COORD_BITS_DEF + 3,
    parameter int FRAC     = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [MAG_BITS-1:0]      num,
    input  logic [MAG_BITS-1:0]      den,
    output logic [MAG_BITS+FRAC-1:0] quo
);

    localparam int QW = MAG_BITS + FRAC;

    logic [MAG_BITS-1:0] rem_reg  [QW+1];
    logic [QW-1:0]       work_reg [QW+1];
    logic [MAG_BITS-1:0] den_reg  [QW+1];
    logic [MAG_BITS-1:0] rem_next [QW+1];
    logic [QW-1:0]       work_next[QW+1];
    logic [MAG_BITS-1:0] den_next [QW+1];
    logic [MAG_BITS:0]   trial    [QW];
    logic [MAG_BITS:0]   diff     [QW];
    logic                ge       [QW];

    // Shift one dividend bit into the remainder and try a subtract per stage
    always_comb
    begin
        rem_next[0]  = '0;
        work_next[0] = {num, {FRAC{1'b0}}};
        den_next[0]  = den;
        for (int k = 0; k < QW; k++)
        begin
            trial[k]       = {rem_reg[k], work_reg[k][QW-1]};
            diff[k]        = trial[k] - {1'b0, den_reg[k]};
            ge[k]          = (trial[k] >= {1'b0, den_reg[k]});
            rem_next[k+1]  = ge[k] ? diff[k][MAG_BITS-1:0] : trial[k][MAG_BITS-1:0];
            work_next[k+1] = {work_reg[k][QW-2:0], ge[k]};
            den_next[k+1]  = den_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                work_reg[k] <= work_next[k];
                den_reg[k]  <= den_next[k];
            end
        end
    end

    assign quo = work_reg[QW];

endmodule

@@ src/bw_back.sv @@
// ----------------------------------------------------------------------------
// Barycentric weights back part
// Divides both numerators, forms the third weight and saturates results.
// ----------------------------------------------------------------------------
module bw_back
    import bw_pkg::*;
#(
    parameter int MAG_BITS = 2 * COORD_BITS_DEF + 3,
    parameter int FRAC     = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  logic [MAG_BITS-1:0]           q_mag0,
    input  logic [MAG_BITS-1:0]           q_mag1,
    input  logic [MAG_BITS-1:0]           q_magd,
    input  bw_flags_t                     q_flags,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [WEIGHT_BITS-1:0] weight0,
    output logic signed [WEIGHT_BITS-1:0] weight1,
    output logic signed [WEIGHT_BITS-1:0] weight2,
    output logic                          degenerate,
    output logic                          saturated
);

    localparam int QW = MAG_BITS + FRAC;
    localparam int WW = QW + 1;
    localparam int SW = QW + 3;
    localparam logic signed [SW-1:0] OUT_MAX = SW'(2 ** (WEIGHT_BITS - 1) - 1);
    localparam logic signed [SW-1:0] OUT_MIN = -OUT_MAX - SW'(1);

    logic                 adv;
    logic [QW-1:0]        quo0, quo1;
    logic                 vld_reg [QW+1];
    bw_flags_t            flg_reg [QW+1];
    logic                 a_valid_reg;
    bw_flags_t            a_flg_reg;
    logic signed [WW-1:0] a_w0_reg, a_w1_reg;
    logic signed [WW-1:0] m0, m1;
    logic signed [SW-1:0] one_fx, v0, v1, v2;
    logic                 out_valid_reg, out_valid_next;
    logic signed [WEIGHT_BITS-1:0] w0_reg, w1_reg, w2_reg;
    logic                 degen_reg, sat_reg;

    function automatic logic over(input logic signed [SW-1:0] v);
        over = (v > OUT_MAX) || (v < OUT_MIN);
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] clip(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        c = (v > OUT_MAX) ? OUT_MAX : ((v < OUT_MIN) ? OUT_MIN : v);
        clip = c[WEIGHT_BITS-1:0];
    endfunction

    // Move the whole back part when the output register can take a request
    assign adv   = !out_valid_reg || !out_stall;
    assign q_pop = q_valid && adv;

    bw_div #(.MAG_BITS(MAG_BITS), .FRAC(FRAC)) u_div0 (
        .clk (clk),
        .en  (adv),
        .num (q_mag0),
        .den (q_magd),
        .quo (quo0)
    );

    bw_div #(.MAG_BITS(MAG_BITS), .FRAC(FRAC)) u_div1 (
        .clk (clk),
        .en  (adv),
        .num (q_mag1),
        .den (q_magd),
        .quo (quo1)
    );

    // Carry valid bits alongside the divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= q_valid;
            for (int k = 0; k < QW; k++)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
            a_valid_reg   <= vld_reg[QW];
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid_next = a_valid_reg;

    // Apply signs to the quotients
    assign m0 = $signed({1'b0, quo0});
    assign m1 = $signed({1'b0, quo1});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flg_reg[0] <= q_flags;
            for (int k = 0; k < QW; k++)
            begin
                flg_reg[k+1] <= flg_reg[k];
            end
            a_flg_reg <= flg_reg[QW];
            a_w0_reg  <= flg_reg[QW].neg0 ? -m0 : m0;
            a_w1_reg  <= flg_reg[QW].neg1 ? -m1 : m1;
        end
    end

    // Form the third weight and saturate all three
    assign one_fx = SW'(1) <<< FRAC;
    assign v0     = SW'(a_w0_reg);
    assign v1     = SW'(a_w1_reg);
    assign v2     = one_fx - v0 - v1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (a_flg_reg.degenerate)
            begin
                w0_reg  <= '0;
                w1_reg  <= clip(one_fx);
                w2_reg  <= '0;
                sat_reg <= over(one_fx);
            end
            else
            begin
                w0_reg  <= clip(v0);
                w1_reg  <= clip(v1);
                w2_reg  <= clip(v2);
                sat_reg <= over(v0) || over(v1) || over(v2);
            end
            degen_reg <= a_flg_reg.degenerate;
        end
    end

    assign out_valid  = out_valid_reg;
    assign weight0    = w0_reg;
    assign weight1    = w1_reg;
    assign weight2    = w2_reg;
    assign degenerate = degen_reg;
    assign saturated  = sat_reg;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && degen_reg) |-> (w0_reg == '0 && w2_reg == '0))
        else $error("degenerate result with nonzero outer weights");

    a_pop_feeds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> vld_reg[0])
        else $error("popped request lost at divider entry");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(w0_reg)))
        else $error("stalled result changed");

endmodule

@@ tb/bw_checker.sv @@
// ----------------------------------------------------------------------------
// Barycentric weights checker
// Watches both channels of the core, predicts the weights and flags of each
// accepted request and compares every accepted result with the oldest one.
// ----------------------------------------------------------------------------
module bw_checker
    import bw_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic signed [15:0]            point_x,
    input  logic signed [15:0]            point_y,
    input  logic signed [15:0]            vertex0_x,
    input  logic signed [15:0]            vertex0_y,
    input  logic signed [15:0]            vertex1_x,
    input  logic signed [15:0]            vertex1_y,
    input  logic signed [15:0]            vertex2_x,
    input  logic signed [15:0]            vertex2_y,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic signed [WEIGHT_BITS-1:0] weight0,
    input  logic signed [WEIGHT_BITS-1:0] weight1,
    input  logic signed [WEIGHT_BITS-1:0] weight2,
    input  logic                          degenerate,
    input  logic                          saturated,
    output int                            fail_count,
    output int                            weights_pending
);

    localparam longint ONE     = longint'(1) << FRAC_BITS_DEF;
    localparam longint OUT_MAX = (longint'(1) << (WEIGHT_BITS - 1)) - 1;
    localparam longint OUT_MIN = -(longint'(1) << (WEIGHT_BITS - 1));

    typedef struct {
        logic signed [WEIGHT_BITS-1:0] w0;
        logic signed [WEIGHT_BITS-1:0] w1;
        logic signed [WEIGHT_BITS-1:0] w2;
        logic                          degen;
        logic                          sat;
    } weights_t;

    weights_t weights_due[$];

    // Quotient n*2^FRAC/d truncated toward zero
    function automatic longint fixed_quotient(longint n, longint d);
        longint un;
        longint ud;
        longint q;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q  = (un << FRAC_BITS_DEF) / ud;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    // Clamp to the weight range, note any clamping
    function automatic logic [WEIGHT_BITS-1:0] clamp_weight(longint v, inout logic sat);
        if (v > OUT_MAX)
        begin
            sat = 1'b1;
            return OUT_MAX[WEIGHT_BITS-1:0];
        end
        if (v < OUT_MIN)
        begin
            sat = 1'b1;
            return OUT_MIN[WEIGHT_BITS-1:0];
        end
        return v[WEIGHT_BITS-1:0];
    endfunction

    function automatic weights_t predict_weights(longint px, longint py, longint x0,
                                                 longint y0, longint x1, longint y1,
                                                 longint x2, longint y2);
        weights_t r;
        longint   n0;
        longint   n1;
        longint   d;
        longint   q0;
        longint   q1;
        logic     sat;
        n0  = (y1 - y2) * (px - x2) + (x2 - x1) * (py - y2);
        n1  = (y2 - y0) * (px - x2) + (x0 - x2) * (py - y2);
        d   = (y1 - y2) * (x0 - x2) + (x2 - x1) * (y0 - y2);
        sat = 1'b0;
        if (d == 0)
        begin
            r.w0    = '0;
            r.w1    = clamp_weight(ONE, sat);
            r.w2    = '0;
            r.degen = 1'b1;
        end
        else
        begin
            q0      = fixed_quotient(n0, d);
            q1      = fixed_quotient(n1, d);
            r.w0    = clamp_weight(q0, sat);
            r.w1    = clamp_weight(q1, sat);
            r.w2    = clamp_weight(ONE - q0 - q1, sat);
            r.degen = 1'b0;
        end
        r.sat = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    assign weights_pending = weights_due.size();

    initial fail_count = 0;

    always @(posedge clk)
    begin
        weights_t want;
        if (rst_n)
        begin
            // Predict each accepted request
            if (in_valid && !in_stall)
                weights_due.push_back(predict_weights(point_x, point_y, vertex0_x,
                    vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y));
            // Compare each accepted result with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (weights_due.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    want = weights_due.pop_front();
                    if (weight0 !== want.w0)
                        report_mismatch("weight0", weight0, want.w0);
                    if (weight1 !== want.w1)
                        report_mismatch("weight1", weight1, want.w1);
                    if (weight2 !== want.w2)
                        report_mismatch("weight2", weight2, want.w2);
                    if (degenerate !== want.degen)
                        report_mismatch("degenerate", degenerate, want.degen);
                    if (saturated !== want.sat)
                        report_mismatch("saturated", saturated, want.sat);
                end
            end
        end
    end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Barycentric weights testbench
// Drives directed and random triangles into the core with random gaps and
// output stalls, one long hold-off included, and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import bw_pkg::*;

    localparam int RANDOM_ITEMS = 1880;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic signed [15:0]            point_x;
    logic signed [15:0]            point_y;
    logic signed [15:0]            vertex0_x;
    logic signed [15:0]            vertex0_y;
    logic signed [15:0]            vertex1_x;
    logic signed [15:0]            vertex1_y;
    logic signed [15:0]            vertex2_x;
    logic signed [15:0]            vertex2_y;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [WEIGHT_BITS-1:0] weight0;
    logic signed [WEIGHT_BITS-1:0] weight1;
    logic signed [WEIGHT_BITS-1:0] weight2;
    logic                          degenerate;
    logic                          saturated;
    int                            fail_count;
    int                            weights_pending;
    bit                            hold_off_req;

    barycentric_weights_core u_dut (.*);

    bw_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one request and hold it until accepted, then maybe idle
    task automatic send_request(int px, int py, int x0, int y0, int x1, int y1,
                                int x2, int y2);
        int gap;
        in_valid  <= 1'b1;
        point_x   <= px[15:0];
        point_y   <= py[15:0];
        vertex0_x <= x0[15:0];
        vertex0_y <= y0[15:0];
        vertex1_x <= x1[15:0];
        vertex1_y <= y1[15:0];
        vertex2_x <= x2[15:0];
        vertex2_y <= y2[15:0];
        @(posedge clk iff !in_stall);
        gap = gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic int full_coord();
        return $signed($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int near(int c, int span);
        int v;
        v = c + $signed($urandom_range(0, 2 * span)) - span;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int len;
        out_stall <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_off_req = 1'b0;
            end
            len = $urandom_range(0, 99) < 30 ? 0 : gap_length() + 1;
            if (len > 0)
            begin
                out_stall <= 1'b0;
                repeat (len) @(posedge clk);
            end
            len = gap_length();
            if (len > 0)
            begin
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int kind;
        int bx;
        int by;
        int dx;
        int dy;
        int a;
        int b;
        int drain;
        hold_off_req = 1'b0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        point_x   <= '0;
        point_y   <= '0;
        vertex0_x <= '0;
        vertex0_y <= '0;
        vertex1_x <= '0;
        vertex1_y <= '0;
        vertex2_x <= '0;
        vertex2_y <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: plain triangle, its vertices, extremes
        send_request(10, 10, 0, 0, 100, 0, 0, 100);
        send_request(0, 0, 0, 0, 100, 0, 0, 100);
        send_request(100, 0, 0, 0, 100, 0, 0, 100);
        send_request(0, 100, 0, 0, 100, 0, 0, 100);
        send_request(-50, -50, 0, 0, 100, 0, 0, 100);
        send_request(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
        send_request(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        send_request(0, 0, -32768, -32768, 32767, -32768, -32768, 32767);
        send_request(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767);
        // Collinear vertices: all equal, on a line, extremes
        send_request(5, 5, 0, 0, 0, 0, 0, 0);
        send_request(7, -3, 0, 0, 10, 10, 20, 20);
        send_request(32767, -32768, -32768, -32768, 32767, 32767, 0, 0);
        send_request(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767);
        // Out of range weights: tiny triangle, far point, both signs
        send_request(32767, 32767, 0, 0, 1, 0, 0, 1);
        send_request(-32768, -32768, 0, 0, 1, 0, 0, 1);
        send_request(-32768, 32767, 0, 0, 0, 1, 1, 0);
        send_request(20, -20, 0, 0, 1, 0, 0, 1);
        send_request(7, 0, 0, 0, 1, 0, 0, 1);
        send_request(8, 0, 0, 0, 1, 0, 0, 1);
        send_request(-8, 0, 0, 0, 1, 0, 0, 1);
        send_request(-9, 0, 0, 0, 1, 0, 0, 1);
        send_request(1, 1, 0, 0, 3, 0, 0, 3);

        // Random part
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 600)
                hold_off_req = 1'b1;
            kind = $urandom_range(0, 99);
            bx = full_coord();
            by = full_coord();
            if (kind < 25)
                send_request(full_coord(), full_coord(), full_coord(), full_coord(),
                             full_coord(), full_coord(), full_coord(), full_coord());
            else if (kind < 60)
                send_request(near(bx, 300), near(by, 300), near(bx, 200), near(by, 200),
                             near(bx, 200), near(by, 200), near(bx, 200), near(by, 200));
            else if (kind < 75)
            begin
                // collinear
                dx = $signed($urandom_range(0, 100)) - 50;
                dy = $signed($urandom_range(0, 100)) - 50;
                a  = $signed($urandom_range(0, 40)) - 20;
                b  = $signed($urandom_range(0, 40)) - 20;
                bx = near(0, 30000);
                by = near(0, 30000);
                send_request(full_coord(), full_coord(), bx, by, bx + a * dx, by + a * dy,
                             bx + b * dx, by + b * dy);
            end
            else if (kind < 88)
            begin
                // tiny triangle, point anywhere
                bx = near(0, 32000);
                by = near(0, 32000);
                a  = $urandom_range(0, 1);
                send_request(near(bx, $urandom_range(1, 32000)),
                             near(by, $urandom_range(1, 32000)),
                             bx, by, bx + 1 - a, by + a, bx + a, by + 1 - a);
            end
            else
                send_request(near(bx, 20), near(by, 20), near(bx, 3), near(by, 3),
                             near(bx, 3), near(by, 3), near(bx, 3), near(by, 3));
        end
        in_valid <= 1'b0;

        // Drain, then let the pipeline settle
        drain = 0;
        while (weights_pending != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (120) @(posedge clk);
        if (fail_count == 0 && weights_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
